// ===== rtl/rms_db_level_meter_defines.svh =====
// assertion macros for the rms level meter
// no dependencies; included by the top level only
`ifndef RMS_DB_LEVEL_METER_DEFINES_SVH
`define RMS_DB_LEVEL_METER_DEFINES_SVH

// implication in the same cycle
`define RDL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rms level meter: check failed");

// implication in the next cycle
`define RDL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rms level meter: check failed");

`endif

// ===== rtl/rdl_pkg.sv =====
// shared types, constants and state encoding for the rms level meter
// no dependencies; used by every module of the block
package rdl_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int LEVEL_W       = 7;
    localparam int FLEN_W        = 13;
    localparam int SQUARE_W      = 31;
    localparam int MANT_W        = 32;
    localparam int LOG_FRAC_W    = 16;
    localparam int MAX_FRAME_DEF = 4096;
    localparam int QUEUE_DEPTH   = 2;
    localparam int LEVEL_MAX     = 100;
    localparam int FULL_SCALE_L2 = 30;
    localparam int LEVEL_K_Q24   = 84174088;
    localparam int LEVEL_K_W     = 28;
    localparam int SCORE_SHIFT   = 40;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [FLEN_W-1:0]  frame_length;
    } result_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NORM,
        B_ITER,
        B_DIFF,
        B_MUL,
        B_SCORE,
        B_OUT
    } back_state_t;

endpackage

// ===== rtl/rms_db_level_meter.sv =====
// rms loudness meter, top level: front end, frame queue, back end, result queue
// depends on rdl_pkg, rdl_front, rdl_fifo, rdl_back and the assertion macro header
//
// The front end takes one sample per clock while the frame queue has room, squares it in a
// registered multiplier and adds it to the frame energy, which starts at 1. A frame closes
// on a sample with last set, or when MAX_FRAME samples have come in. Each closed frame waits
// in a two-entry queue for the back end, which works out the score with one shared normaliser
// and one 32x32 squaring stage. Per frame it takes the frame from the queue, normalises the
// energy (in a 30+clog2(MAX_FRAME+1) bit register, one bit a cycle) and takes its log in 16
// squaring steps, does the same for the count, and then subtracts, scales, clamps and hands
// the result on, waiting while the result queue is full. Long frames therefore run at one
// sample a clock; frames shorter than the back end's time fill the queue and full rises until
// a frame has been scored. Results wait in a two-entry queue, so pop may stall freely.
`include "rms_db_level_meter_defines.svh"

module rms_db_level_meter #(
    parameter int MAX_FRAME = rdl_pkg::MAX_FRAME_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  rdl_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output rdl_pkg::result_t result
);
    import rdl_pkg::*;

    localparam int CNT_W   = $clog2(MAX_FRAME + 1);
    localparam int FRAME_W = FULL_SCALE_L2 + 2 * CNT_W;
    localparam int RES_W   = $bits(result_t);

    logic               q_push, q_full, q_pop, q_empty;
    logic [FRAME_W-1:0] q_wdata, q_rdata;
    logic               r_push, r_full;
    result_t            r_wdata;
    logic [RES_W-1:0]   r_rdata;

    rdl_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_push (q_push),
        .q_full (q_full),
        .q_data (q_wdata)
    );

    rdl_fifo #(
        .WIDTH (FRAME_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_frame_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    rdl_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_data  (q_rdata),
        .r_full  (r_full),
        .r_push  (r_push),
        .r_data  (r_wdata)
    );

    rdl_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (r_push),
        .wdata (r_wdata),
        .full  (r_full),
        .rd    (pop),
        .rdata (r_rdata),
        .empty (empty)
    );

    assign result = result_t'(r_rdata);

    `RDL_ASSERT_NOW(a_frame_q_no_overrun, q_push, !q_full)
    `RDL_ASSERT_NOW(a_result_q_no_overrun, r_push, !r_full)
    `RDL_ASSERT_NOW(a_level_in_range, !empty, result.level <= LEVEL_W'(LEVEL_MAX))
    `RDL_ASSERT_NEXT(a_frame_q_pop_starts_work, q_pop, !q_pop)

endmodule

// ===== rtl/rdl_fifo.sv =====
// small register queue used between the front and back ends and on the result side
// depends on rdl_pkg for the default depth
module rdl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rdl_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    import rdl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_wr, do_rd;

    assign full  = (fill_reg == CNT_W'(DEPTH));
    assign empty = (fill_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/rdl_front.sv =====
// front end: takes samples, squares them and accumulates the frame energy
// depends on rdl_pkg; hands finished frames to the frame queue
module rdl_front #(
    parameter int MAX_FRAME = rdl_pkg::MAX_FRAME_DEF
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 push,
    output logic                                                 full,
    input  rdl_pkg::item_t                                       item,
    output logic                                                 q_push,
    input  logic                                                 q_full,
    output logic [rdl_pkg::FULL_SCALE_L2+2*$clog2(MAX_FRAME+1)-1:0] q_data
);
    import rdl_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int SUM_W = FULL_SCALE_L2 + CNT_W;

    logic                    s1_valid_reg, s1_valid_next;
    logic                    s1_last_reg, s1_last_next;
    logic [SQUARE_W-1:0]     sq_reg, sq_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [2*SAMPLE_W-1:0] square;
    logic [SUM_W-1:0]        sum_add;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    frame_end;
    logic                    advance;
    logic                    accept;

    assign square    = item.sample * item.sample;
    assign sum_add   = sum_reg + SUM_W'(sq_reg);
    assign cnt_inc   = cnt_reg + 1'b1;
    assign frame_end = s1_last_reg || (cnt_inc >= CNT_W'(MAX_FRAME));
    assign advance   = s1_valid_reg && !(frame_end && q_full);
    assign full      = s1_valid_reg && !advance;
    assign accept    = push && !full;
    assign q_push    = advance && frame_end;
    assign q_data    = {sum_add, cnt_inc};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_last_next  = s1_last_reg;
        sq_next       = sq_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        if (advance)
        begin
            s1_valid_next = 1'b0;
            sum_next      = frame_end ? SUM_W'(1) : sum_add;
            cnt_next      = frame_end ? '0 : cnt_inc;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_last_next  = item.last;
            sq_next       = square[SQUARE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sum_reg      <= SUM_W'(1);
            cnt_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= s1_last_next;
        sq_reg      <= sq_next;
    end

endmodule

// ===== rtl/rdl_back.sv =====
// back end: fixed-point log2 of frame energy and count, then the 0..100 score
// depends on rdl_pkg; reads the frame queue and writes the result queue
module rdl_back #(
    parameter int MAX_FRAME = rdl_pkg::MAX_FRAME_DEF
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 q_empty,
    output logic                                                 q_pop,
    input  logic [rdl_pkg::FULL_SCALE_L2+2*$clog2(MAX_FRAME+1)-1:0] q_data,
    input  logic                                                 r_full,
    output logic                                                 r_push,
    output rdl_pkg::result_t                                     r_data
);
    import rdl_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int SUM_W = FULL_SCALE_L2 + CNT_W;
    localparam int EXP_W = $clog2(SUM_W);
    localparam int LOG_W = EXP_W + LOG_FRAC_W;
    localparam int D_W   = LOG_W + 2;
    localparam int P_W   = D_W + LEVEL_K_W;
    localparam int T_W   = ((P_W > SCORE_SHIFT + 7) ? P_W : SCORE_SHIFT + 7) + 2;
    localparam int V_W   = T_W - SCORE_SHIFT;
    localparam int FL_W  = (CNT_W > FLEN_W) ? CNT_W : FLEN_W;
    localparam int ITER_W = $clog2(LOG_FRAC_W);

    back_state_t             state_reg, state_next;
    logic [SUM_W-1:0]        norm_reg, norm_next;
    logic [EXP_W-1:0]        exp_reg, exp_next;
    logic [MANT_W-1:0]       m_reg, m_next;
    logic [LOG_FRAC_W-1:0]   frac_reg, frac_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    logic                    phase_reg, phase_next;
    logic [CNT_W-1:0]        cnt_hold_reg, cnt_hold_next;
    logic [LOG_W-1:0]        log_sum_reg, log_sum_next;
    logic [LOG_W-1:0]        log_cnt_reg, log_cnt_next;
    logic signed [D_W-1:0]   diff_reg, diff_next;
    logic signed [P_W-1:0]   prod_reg, prod_next;
    result_t                 res_reg, res_next;

    logic [2*MANT_W-1:0]     sq;
    logic                    frac_bit;
    logic [LOG_FRAC_W-1:0]   frac_shift;
    logic                    iter_done;
    logic signed [T_W-1:0]   t_val;
    logic [V_W-1:0]          v_val;
    logic [FL_W-1:0]         flen_ext;
    logic [SUM_W-1:0]        q_sum;
    logic [CNT_W-1:0]        q_cnt;

    assign q_sum      = q_data[SUM_W+CNT_W-1:CNT_W];
    assign q_cnt      = q_data[CNT_W-1:0];
    assign sq         = m_reg * m_reg;
    assign frac_bit   = sq[2*MANT_W-1];
    assign frac_shift = {frac_reg[LOG_FRAC_W-2:0], frac_bit};
    assign iter_done  = (iter_reg == ITER_W'(LOG_FRAC_W - 1));
    assign t_val      = (T_W'(LEVEL_MAX) <<< SCORE_SHIFT) + T_W'(prod_reg);
    assign v_val      = t_val[T_W-1:SCORE_SHIFT];
    assign flen_ext   = FL_W'(cnt_hold_reg);
    assign r_data     = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_NORM;
                end
            end
            B_NORM:
            begin
                if (norm_reg[SUM_W-1])
                begin
                    state_next = B_ITER;
                end
            end
            B_ITER:
            begin
                if (iter_done)
                begin
                    state_next = phase_reg ? B_DIFF : B_NORM;
                end
            end
            B_DIFF:  state_next = B_MUL;
            B_MUL:   state_next = B_SCORE;
            B_SCORE: state_next = B_OUT;
            B_OUT:
            begin
                if (!r_full)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // queue handshakes
    always_comb
    begin
        q_pop  = 1'b0;
        r_push = 1'b0;
        unique case (state_reg)
            B_IDLE:  q_pop  = !q_empty;
            B_OUT:   r_push = !r_full;
            default:
            begin
                q_pop  = 1'b0;
                r_push = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        norm_next     = norm_reg;
        exp_next      = exp_reg;
        m_next        = m_reg;
        frac_next     = frac_reg;
        iter_next     = iter_reg;
        phase_next    = phase_reg;
        cnt_hold_next = cnt_hold_reg;
        log_sum_next  = log_sum_reg;
        log_cnt_next  = log_cnt_reg;
        diff_next     = diff_reg;
        prod_next     = prod_reg;
        res_next      = res_reg;
        case (state_reg)
            B_IDLE:
            begin
                norm_next     = q_sum;
                cnt_hold_next = q_cnt;
                exp_next      = EXP_W'(SUM_W - 1);
                phase_next    = 1'b0;
            end
            B_NORM:
            begin
                if (norm_reg[SUM_W-1])
                begin
                    m_next    = norm_reg[SUM_W-1 -: MANT_W];
                    frac_next = '0;
                    iter_next = '0;
                end
                else
                begin
                    norm_next = {norm_reg[SUM_W-2:0], 1'b0};
                    exp_next  = exp_reg - 1'b1;
                end
            end
            B_ITER:
            begin
                m_next    = frac_bit ? sq[2*MANT_W-1:MANT_W] : sq[2*MANT_W-2:MANT_W-1];
                frac_next = frac_shift;
                iter_next = iter_reg + 1'b1;
                if (iter_done)
                begin
                    if (phase_reg)
                    begin
                        log_cnt_next = {exp_reg, frac_shift};
                    end
                    else
                    begin
                        log_sum_next = {exp_reg, frac_shift};
                        norm_next    = SUM_W'(cnt_hold_reg);
                        exp_next     = EXP_W'(SUM_W - 1);
                        phase_next   = 1'b1;
                    end
                end
            end
            B_DIFF:
            begin
                diff_next = $signed({2'b00, log_sum_reg}) - $signed({2'b00, log_cnt_reg})
                          - D_W'(FULL_SCALE_L2 << LOG_FRAC_W);
            end
            B_MUL:
            begin
                prod_next = diff_reg * $signed(LEVEL_K_W'(LEVEL_K_Q24));
            end
            B_SCORE:
            begin
                res_next.frame_length = flen_ext[FLEN_W-1:0];
                if (t_val[T_W-1])
                begin
                    res_next.level = '0;
                end
                else if (v_val > V_W'(LEVEL_MAX))
                begin
                    res_next.level = LEVEL_W'(LEVEL_MAX);
                end
                else
                begin
                    res_next.level = v_val[LEVEL_W-1:0];
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg     <= norm_next;
        exp_reg      <= exp_next;
        m_reg        <= m_next;
        frac_reg     <= frac_next;
        iter_reg     <= iter_next;
        phase_reg    <= phase_next;
        cnt_hold_reg <= cnt_hold_next;
        log_sum_reg  <= log_sum_next;
        log_cnt_reg  <= log_cnt_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
    end

endmodule

// ===== tb/tb_rms_db_level_meter.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the rms level meter: queue-driven sample sender, result monitor
// and a bit-exact fixed-point loudness predictor; depends on rdl_pkg and rms_db_level_meter
module tb_rms_db_level_meter;
    import rdl_pkg::*;

    localparam int FRAME_MAX     = MAX_FRAME_DEF;
    localparam int IDLE_MAX      = 18;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 400;
    localparam int RANDOM_ITEMS  = 2000;

    typedef struct {
        item_t req;
        bit    drain;
    } sample_request_t;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    logic    pop   = 1'b0;
    item_t   item  = '0;
    logic    full;
    logic    empty;
    result_t result;

    sample_request_t sample_requests[$];
    result_t         expected_scores[$];

    logic [63:0] frame_energy = 64'd1;
    int unsigned frame_count  = 0;

    int n_queued    = 0;
    int n_issued    = 0;
    int n_accepted  = 0;
    int n_popped    = 0;
    int n_pop_seen  = 0;
    int errors      = 0;
    int idle_cycles = 0;
    int send_gap    = 0;
    int pop_gap     = 0;
    bit send_calm   = 1'b0;
    bit pop_calm    = 1'b0;

    rms_db_level_meter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // log2 in q16: msb index plus 16 fraction bits by repeated squaring
    function automatic int unsigned log2_q16(input logic [63:0] x);
        int unsigned msb;
        int unsigned frac;
        logic [63:0] m;
        msb = 0;
        frac = 0;
        if (x == 64'd0)
            return 0;
        for (int i = 0; i < 64; i++)
            if (x[i])
                msb = i;
        if (msb <= 31)
            m = x << (31 - msb);
        else
            m = x >> (msb - 31);
        repeat (LOG_FRAC_W)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (msb << LOG_FRAC_W) | frac;
    endfunction

    function automatic logic [LEVEL_W-1:0] loudness_score(input logic [63:0] energy,
                                                           input int unsigned count);
        longint d;
        longint t;
        d = longint'(log2_q16(energy)) - longint'(log2_q16(64'(count)))
            - (longint'(FULL_SCALE_L2) << LOG_FRAC_W);
        t = (longint'(LEVEL_MAX) << SCORE_SHIFT) + d * longint'(LEVEL_K_Q24);
        if (t < 0)
            return '0;
        t = t >>> SCORE_SHIFT;
        if (t > LEVEL_MAX)
            t = LEVEL_MAX;
        return t[LEVEL_W-1:0];
    endfunction

    task automatic take_sample(input item_t req);
        longint  s;
        result_t r;
        s = longint'(req.sample);
        frame_energy = frame_energy + 64'(s * s);
        frame_count++;
        if (req.last || frame_count >= FRAME_MAX)
        begin
            r.level = loudness_score(frame_energy, frame_count);
            r.frame_length = frame_count[FLEN_W-1:0];
            expected_scores.push_back(r);
            frame_energy = 64'd1;
            frame_count = 0;
        end
    endtask

    task automatic queue_sample(input logic signed [SAMPLE_W-1:0] s, input bit last,
                                input bit drain = 1'b0);
        sample_request_t q;
        q.req.sample = s;
        q.req.last = last;
        q.drain = drain;
        sample_requests.push_back(q);
        n_queued++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        logic signed [SAMPLE_W-1:0] s;
        s = SAMPLE_W'($urandom);
        return s >>> $urandom_range(0, SAMPLE_W - 1);
    endfunction

    always @(negedge clk)
    begin : sender
        logic nxt_push;
        if (rst_n)
        begin
            nxt_push = push;
            if (!push || n_accepted == n_issued)
            begin
                nxt_push = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (sample_requests.size() > 0 &&
                         !(sample_requests[0].drain && expected_scores.size() != 0))
                begin
                    item <= sample_requests[0].req;
                    sample_requests.pop_front();
                    n_issued++;
                    nxt_push = 1'b1;
                    if ($urandom_range(0, 99) == 0)
                        send_calm = !send_calm;
                    send_gap = send_calm ? 0 : $urandom_range(0, IDLE_MAX);
                end
            end
            push <= nxt_push;
        end
    end

    always @(negedge clk)
    begin : receiver
        if (rst_n)
        begin
            if (pop && n_popped != n_pop_seen)
            begin
                n_pop_seen = n_popped;
                if ($urandom_range(0, 99) == 0)
                    pop_calm = !pop_calm;
                pop_gap = pop_calm ? 0 : $urandom_range(0, IDLE_MAX);
            end
            if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                n_popped++;
                if (expected_scores.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got level %0d length %0d",
                             $time, result.level, result.frame_length);
                end
                else
                begin
                    want = expected_scores.pop_front();
                    if (result.level !== want.level)
                    begin
                        errors++;
                        $display("%0t: level mismatch, expected %0d, got %0d",
                                 $time, want.level, result.level);
                    end
                    if (result.frame_length !== want.frame_length)
                    begin
                        errors++;
                        $display("%0t: frame_length mismatch, expected %0d, got %0d",
                                 $time, want.frame_length, result.frame_length);
                    end
                end
            end
            if (push && !full)
            begin
                n_accepted++;
                take_sample(item);
            end
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int len;
        int kind;
        int frame_no;
        int random_count;
        bit drain;

        // directed frames: silence, full scale, single samples, mixed short frames
        for (int i = 0; i < 8; i++)
            queue_sample('0, i == 7);
        queue_sample(-16'sd32768, 1'b1);
        queue_sample(16'sd32767, 1'b1);
        queue_sample(16'sd0, 1'b1);
        queue_sample(16'sd1, 1'b1);
        queue_sample(-16'sd1, 1'b1);
        queue_sample(16'sd16384, 1'b0);
        queue_sample(-16'sd16384, 1'b0);
        queue_sample(16'sd100, 1'b0);
        queue_sample(-16'sd100, 1'b1);
        queue_sample(16'sd32767, 1'b0);
        queue_sample(-16'sd32768, 1'b1);

        frame_no = 0;
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            drain = (frame_no == 0) || ($urandom_range(0, 39) == 0);
            if (frame_no == 12)
            begin
                // frame closed by the sample count alone, at full scale
                for (int i = 0; i < FRAME_MAX; i++)
                    queue_sample(-16'sd32768, 1'b0, drain && i == 0);
            end
            else
            begin
                kind = $urandom_range(0, 99);
                if (kind < 80)
                begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                      : $urandom_range(1, 40);
                    for (int i = 0; i < len; i++)
                        queue_sample(random_sample(), i == len - 1, drain && i == 0);
                end
                else if (kind < 95)
                begin
                    len = $urandom_range(1, 10);
                    for (int i = 0; i < len; i++)
                        queue_sample(SAMPLE_W'($urandom), 1'($urandom_range(0, 1)),
                                     drain && i == 0);
                end
                else
                begin
                    len = $urandom_range(1, 20);
                    for (int i = 0; i < len; i++)
                        queue_sample('0, i == len - 1, drain && i == 0);
                end
                random_count += len;
            end
            frame_no++;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_accepted < n_queued)
            @(posedge clk);
        while (expected_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rdl_pkg.sv
rtl/rdl_fifo.sv
rtl/rdl_front.sv
rtl/rdl_back.sv
rtl/rms_db_level_meter.sv
tb/tb_rms_db_level_meter.sv
